// ----- hw/rtl/akf_pkg.sv -----
// Package for the two-state altitude Kalman filter core.
// Holds the sequencer state type, the micro-op format and the micro-program.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package akf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIVW,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIV
    } t_op;

    localparam int unsigned PC_W   = 6;
    localparam int unsigned SRC_W  = 6;
    localparam int unsigned ADDR_W = 5;

    // Register file addresses. Operand codes with the top bit set pick a
    // special source instead of the register file.
    localparam logic [SRC_W-1:0] R_POS  = 6'd0;
    localparam logic [SRC_W-1:0] R_VEL  = 6'd1;
    localparam logic [SRC_W-1:0] R_PPP  = 6'd2;
    localparam logic [SRC_W-1:0] R_PPV  = 6'd3;
    localparam logic [SRC_W-1:0] R_PVP  = 6'd4;
    localparam logic [SRC_W-1:0] R_PVV  = 6'd5;
    localparam logic [SRC_W-1:0] R_GAIN = 6'd6;
    localparam logic [SRC_W-1:0] R_T0   = 6'd8;
    localparam logic [SRC_W-1:0] R_T1   = 6'd9;
    localparam logic [SRC_W-1:0] R_T2   = 6'd10;
    localparam logic [SRC_W-1:0] R_K0   = 6'd11;
    localparam logic [SRC_W-1:0] R_K1   = 6'd12;
    localparam logic [SRC_W-1:0] R_C    = 6'd13;
    localparam logic [SRC_W-1:0] R_NK   = 6'd14;
    localparam logic [SRC_W-1:0] R_M00  = 6'd15;
    localparam logic [SRC_W-1:0] R_M01  = 6'd16;
    localparam logic [SRC_W-1:0] R_M10  = 6'd17;
    localparam logic [SRC_W-1:0] R_M11  = 6'd18;
    localparam logic [SRC_W-1:0] R_KR0  = 6'd19;
    localparam logic [SRC_W-1:0] R_KR1  = 6'd20;

    localparam logic [SRC_W-1:0] S_ACC  = 6'h20;
    localparam logic [SRC_W-1:0] S_DT   = 6'h21;
    localparam logic [SRC_W-1:0] S_ALT  = 6'h22;
    localparam logic [SRC_W-1:0] S_Q    = 6'h23;
    localparam logic [SRC_W-1:0] S_R    = 6'h24;
    localparam logic [SRC_W-1:0] S_ONE  = 6'h25;
    localparam logic [SRC_W-1:0] S_HALF = 6'h26;
    localparam logic [SRC_W-1:0] S_ZERO = 6'h27;

    localparam logic [PC_W-1:0] PC_PREDICT = 6'd0;
    localparam logic [PC_W-1:0] PC_UPDATE  = 6'd17;

    localparam logic [1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [1:0] CFG_MEASUREMENT_NOISE = 2'd1;

    typedef struct packed {
        t_op              op;
        logic [SRC_W-1:0] a;
        logic [SRC_W-1:0] b;
        logic [ADDR_W-1:0] dst;
        logic             last;
    } t_uop;

    typedef struct packed {
        logic load_in;
        logic rd;
        logic ex;
        logic wr;
        t_uop uop;
    } t_dp_ctl;

    function automatic t_uop mk(input t_op op, input logic [SRC_W-1:0] a,
                                input logic [SRC_W-1:0] b,
                                input logic [SRC_W-1:0] d, input logic l);
        t_uop u;
        u.op   = op;
        u.a    = a;
        u.b    = b;
        u.dst  = d[ADDR_W-1:0];
        u.last = l;
        return u;
    endfunction

    // Predict runs from PC_PREDICT, the Joseph-form update from PC_UPDATE.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(OP_MUL, S_DT,  S_DT,   R_T0,  1'b0);
            6'd1:  u = mk(OP_MUL, R_T0,  S_HALF, R_T0,  1'b0);
            6'd2:  u = mk(OP_MUL, S_DT,  R_VEL,  R_T1,  1'b0);
            6'd3:  u = mk(OP_ADD, R_POS, R_T1,   R_T1,  1'b0);
            6'd4:  u = mk(OP_MUL, R_T0,  S_ACC,  R_T2,  1'b0);
            6'd5:  u = mk(OP_ADD, R_T1,  R_T2,   R_POS, 1'b0);
            6'd6:  u = mk(OP_MUL, S_DT,  S_ACC,  R_T1,  1'b0);
            6'd7:  u = mk(OP_ADD, R_VEL, R_T1,   R_VEL, 1'b0);
            6'd8:  u = mk(OP_MUL, S_DT,  R_PVP,  R_T1,  1'b0);
            6'd9:  u = mk(OP_ADD, R_PPP, R_T1,   R_T2,  1'b0);
            6'd10: u = mk(OP_MUL, S_DT,  R_PVV,  R_T1,  1'b0);
            6'd11: u = mk(OP_ADD, R_PPV, R_T1,   R_PPV, 1'b0);
            6'd12: u = mk(OP_ADD, R_PVP, R_T1,   R_PVP, 1'b0);
            6'd13: u = mk(OP_MUL, R_PPV, S_DT,   R_T1,  1'b0);
            6'd14: u = mk(OP_ADD, R_T2,  R_T1,   R_T2,  1'b0);
            6'd15: u = mk(OP_ADD, R_T2,  S_Q,    R_PPP, 1'b0);
            6'd16: u = mk(OP_ADD, R_PVV, S_Q,    R_PVV, 1'b1);
            6'd17: u = mk(OP_DIV, R_PPP, R_PPP,  R_K0,  1'b0);
            6'd18: u = mk(OP_DIV, R_PVP, R_PPP,  R_K1,  1'b0);
            6'd19: u = mk(OP_SUB, S_ALT, R_POS,  R_T0,  1'b0);
            6'd20: u = mk(OP_MUL, R_K0,  R_T0,   R_T1,  1'b0);
            6'd21: u = mk(OP_ADD, R_POS, R_T1,   R_POS, 1'b0);
            6'd22: u = mk(OP_MUL, R_K1,  R_T0,   R_T1,  1'b0);
            6'd23: u = mk(OP_ADD, R_VEL, R_T1,   R_VEL, 1'b0);
            6'd24: u = mk(OP_SUB, S_ONE, R_K0,   R_C,   1'b0);
            6'd25: u = mk(OP_SUB, S_ZERO, R_K1,  R_NK,  1'b0);
            6'd26: u = mk(OP_MUL, R_C,   R_PPP,  R_M00, 1'b0);
            6'd27: u = mk(OP_MUL, R_C,   R_PPV,  R_M01, 1'b0);
            6'd28: u = mk(OP_MUL, R_NK,  R_PPP,  R_T1,  1'b0);
            6'd29: u = mk(OP_ADD, R_T1,  R_PVP,  R_M10, 1'b0);
            6'd30: u = mk(OP_MUL, R_NK,  R_PPV,  R_T1,  1'b0);
            6'd31: u = mk(OP_ADD, R_T1,  R_PVV,  R_M11, 1'b0);
            6'd32: u = mk(OP_MUL, R_K0,  S_R,    R_KR0, 1'b0);
            6'd33: u = mk(OP_MUL, R_K1,  S_R,    R_KR1, 1'b0);
            6'd34: u = mk(OP_MUL, R_M00, R_C,    R_T1,  1'b0);
            6'd35: u = mk(OP_MUL, R_KR0, R_K0,   R_T2,  1'b0);
            6'd36: u = mk(OP_ADD, R_T1,  R_T2,   R_PPP, 1'b0);
            6'd37: u = mk(OP_MUL, R_M00, R_NK,   R_T1,  1'b0);
            6'd38: u = mk(OP_ADD, R_T1,  R_M01,  R_T1,  1'b0);
            6'd39: u = mk(OP_MUL, R_KR0, R_K1,   R_T2,  1'b0);
            6'd40: u = mk(OP_ADD, R_T1,  R_T2,   R_PPV, 1'b0);
            6'd41: u = mk(OP_MUL, R_M10, R_C,    R_T1,  1'b0);
            6'd42: u = mk(OP_MUL, R_KR1, R_K0,   R_T2,  1'b0);
            6'd43: u = mk(OP_ADD, R_T1,  R_T2,   R_PVP, 1'b0);
            6'd44: u = mk(OP_MUL, R_M10, R_NK,   R_T1,  1'b0);
            6'd45: u = mk(OP_ADD, R_T1,  R_M11,  R_T1,  1'b0);
            6'd46: u = mk(OP_MUL, R_KR1, R_K1,   R_T2,  1'b0);
            6'd47: u = mk(OP_ADD, R_T1,  R_T2,   R_PVV, 1'b0);
            6'd48: u = mk(OP_ADD, R_K1,  S_ZERO, R_GAIN, 1'b1);
            default: u = mk(OP_ADD, S_ZERO, S_ZERO, R_T0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/akf_in_if.sv -----
// Input channel of the altitude Kalman filter: one measurement or predict beat.
// Valid/ready handshake. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface akf_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] accel;
    logic [23:0]        delta_t;
    logic signed [31:0] altitude;

    modport source (output valid, mode, accel, delta_t, altitude, input ready);
    modport sink   (input valid, mode, accel, delta_t, altitude, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/akf_out_if.sv -----
// Result channel of the altitude Kalman filter: state estimate per beat.
// Valid/ready handshake. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface akf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] velocity_gain;
    logic               overflow;

    modport source (output valid, position, velocity, velocity_gain, overflow,
                    input ready);
    modport sink   (input valid, position, velocity, velocity_gain, overflow,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/akf_cfg_if.sv -----
// Configuration write channel of the altitude Kalman filter.
// Valid/ready handshake carrying register index and data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface akf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/akf_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, for the gain.
// Computes sat((num << FRAC_BITS) / den) truncated toward zero. Uses akf_pkg-free logic.
`timescale 1ns / 1ps
`default_nettype none

module akf_div #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [32:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quo,
    output logic                    o_ovf
);
    localparam int unsigned NW    = 32 + FRAC_BITS;
    localparam int unsigned CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_n;
    logic [32:0]      r_rem;
    logic [32:0]      r_dmag;
    logic             r_neg;
    logic             r_zero;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;

    logic [31:0] w_nmag;
    logic [33:0] w_trial;
    logic [33:0] w_shift;
    logic        w_hi;

    assign w_nmag  = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_shift = {r_rem, r_n[NW-1]};
    assign w_trial = w_shift - {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_den != '0);
                r_done <= (i_den == '0);
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_den == '0);
            r_neg  <= i_num[31] ^ i_den[32];
            r_dmag <= i_den[32] ? 33'(-i_den) : 33'(i_den);
            r_n    <= NW'({w_nmag, {FRAC_BITS{1'b0}}});
            r_rem  <= '0;
            r_cnt  <= CNT_W'(NW);
        end else if (r_busy) begin
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_n   <= {r_n[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[32:0];
                r_n   <= {r_n[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Magnitude bits at or above bit 31 decide saturation.
    assign w_hi = |r_n[NW-1:31];

    always_comb begin
        o_ovf = 1'b0;
        o_quo = '0;
        if (!r_zero) begin
            if (!r_neg) begin
                if (w_hi) begin
                    o_ovf = 1'b1;
                    o_quo = 32'sh7FFF_FFFF;
                end else begin
                    o_quo = r_n[31:0];
                end
            end else begin
                if (w_hi && (r_n != NW'(33'h0_8000_0000))) begin
                    o_ovf = 1'b1;
                    o_quo = 32'sh8000_0000;
                end else begin
                    o_quo = -r_n[31:0];
                end
            end
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- hw/rtl/akf_dp.sv -----
// Datapath of the altitude Kalman filter: register file, shared multiply/add
// unit with rounding and saturation, and the gain divider. Depends on akf_pkg
// and akf_div.
`timescale 1ns / 1ps
`default_nettype none

module akf_dp #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire akf_pkg::t_dp_ctl   i_ctl,
    input  wire logic signed [31:0] i_accel,
    input  wire logic [23:0]        i_delta_t,
    input  wire logic signed [31:0] i_altitude,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [30:0]        i_cfg_data,
    output logic                    o_div_done,
    output logic signed [31:0]      o_position,
    output logic signed [31:0]      o_velocity,
    output logic signed [31:0]      o_gain,
    output logic                    o_ovf
);
    localparam int unsigned DEPTH = 2 ** akf_pkg::ADDR_W;
    localparam logic [30:0] Q_RST =
        31'(((64'd75 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [30:0] R_RST = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [31:0] FX_ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] FX_HALF = 32'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    logic signed [31:0] r_acc_in;
    logic signed [31:0] r_alt;
    logic [23:0]        r_dt;
    logic [30:0]        r_q;
    logic [30:0]        r_r;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [63:0] r_acc;
    logic               r_ovf;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_gain;

    logic signed [31:0] w_opa;
    logic signed [31:0] w_opb;
    logic signed [31:0] w_spa;
    logic signed [31:0] w_spb;
    logic signed [63:0] w_rnd;
    logic signed [63:0] w_pre;
    logic signed [31:0] w_val;
    logic               w_ovf;
    logic signed [31:0] w_quo;
    logic               w_div_ovf;
    logic               w_div_start;
    logic signed [32:0] w_den;
    akf_pkg::t_uop      w_u;

    assign w_u = i_ctl.uop;

    function automatic logic signed [31:0] special(
        input logic [akf_pkg::SRC_W-1:0] code, input logic signed [31:0] acc,
        input logic [23:0] dt, input logic signed [31:0] alt,
        input logic [30:0] q, input logic [30:0] r);
        logic signed [31:0] v;
        case (code)
            akf_pkg::S_ACC:  v = acc;
            akf_pkg::S_DT:   v = {8'd0, dt};
            akf_pkg::S_ALT:  v = alt;
            akf_pkg::S_Q:    v = {1'b0, q};
            akf_pkg::S_R:    v = {1'b0, r};
            akf_pkg::S_ONE:  v = FX_ONE;
            akf_pkg::S_HALF: v = FX_HALF;
            default:         v = '0;
        endcase
        return v;
    endfunction

    assign w_spa = special(w_u.a, r_acc_in, r_dt, r_alt, r_q, r_r);
    assign w_spb = special(w_u.b, r_acc_in, r_dt, r_alt, r_q, r_r);

    // Register file read, registered. Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_a <= w_opa;
            r_b <= w_opb;
        end
    end

    always_comb begin
        w_opa = r_valid[w_u.a[akf_pkg::ADDR_W-1:0]] ?
                r_mem[w_u.a[akf_pkg::ADDR_W-1:0]] : '0;
        w_opb = r_valid[w_u.b[akf_pkg::ADDR_W-1:0]] ?
                r_mem[w_u.b[akf_pkg::ADDR_W-1:0]] : '0;
        if (w_u.a[akf_pkg::SRC_W-1]) begin
            w_opa = w_spa;
        end
        if (w_u.b[akf_pkg::SRC_W-1]) begin
            w_opb = w_spb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ex) begin
            case (w_u.op)
                akf_pkg::OP_MUL: r_acc <= r_a * r_b;
                akf_pkg::OP_SUB: r_acc <= 64'(r_a) - 64'(r_b);
                default:         r_acc <= 64'(r_a) + 64'(r_b);
            endcase
        end
    end

    assign w_div_start = i_ctl.ex && (w_u.op == akf_pkg::OP_DIV);
    assign w_den       = 33'(r_b) + 33'({1'b0, r_r});

    akf_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_a),
        .i_den   (w_den),
        .o_done  (o_div_done),
        .o_quo   (w_quo),
        .o_ovf   (w_div_ovf)
    );

    // Products are rounded half up to FRAC_BITS, then every result saturates.
    assign w_rnd = (r_acc + 64'(FX_HALF)) >>> FRAC_BITS;
    assign w_pre = (w_u.op == akf_pkg::OP_MUL) ? w_rnd : r_acc;

    always_comb begin
        if (w_u.op == akf_pkg::OP_DIV) begin
            w_val = w_quo;
            w_ovf = w_div_ovf;
        end else if (w_pre > 64'sh7FFF_FFFF) begin
            w_val = 32'sh7FFF_FFFF;
            w_ovf = 1'b1;
        end else if (w_pre < -64'sh8000_0000) begin
            w_val = 32'sh8000_0000;
            w_ovf = 1'b1;
        end else begin
            w_val = w_pre[31:0];
            w_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[w_u.dst] <= w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
            r_vel   <= '0;
            r_gain  <= '0;
            r_q     <= Q_RST;
            r_r     <= R_RST;
        end else begin
            if (i_cfg_we && (i_cfg_idx == akf_pkg::CFG_PROCESS_NOISE)) begin
                r_q <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == akf_pkg::CFG_MEASUREMENT_NOISE)) begin
                r_r <= i_cfg_data;
            end
            if (i_ctl.load_in) begin
                r_ovf <= 1'b0;
            end else if (i_ctl.wr) begin
                r_ovf <= r_ovf | w_ovf;
            end
            if (i_ctl.wr) begin
                r_valid[w_u.dst] <= 1'b1;
                if (w_u.dst == akf_pkg::R_POS[akf_pkg::ADDR_W-1:0]) begin
                    r_pos <= w_val;
                end
                if (w_u.dst == akf_pkg::R_VEL[akf_pkg::ADDR_W-1:0]) begin
                    r_vel <= w_val;
                end
                if (w_u.dst == akf_pkg::R_GAIN[akf_pkg::ADDR_W-1:0]) begin
                    r_gain <= w_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_acc_in <= i_accel;
            r_dt     <= i_delta_t;
            r_alt    <= i_altitude;
        end
    end

    assign o_position = r_pos;
    assign o_velocity = r_vel;
    assign o_gain     = r_gain;
    assign o_ovf      = r_ovf;

endmodule

`default_nettype wire

// ----- hw/rtl/altitude_kalman_filter_2state_core.sv -----
// Two-state (position, velocity) altitude Kalman filter in signed fixed point.
// Top level: micro-program sequencer and handshakes. Depends on akf_pkg,
// the akf_*_if interfaces and akf_dp.
//
// Usage: i_in carries one beat per step: mode 0 predicts with accel and
// delta_t, mode 1 corrects with a barometric altitude. Each accepted beat
// yields exactly one beat on o_out with position, velocity, the latest
// velocity gain and an overflow flag. i_cfg writes process noise (index 0)
// or measurement noise (index 1) and should only be used while idle.
// One item is in flight at a time: i_in.ready is high only when idle.
// Every micro-op steps through operand read, execute and write back; adds,
// subtracts and multiplies share the one multiply/add unit, while the two
// gain divisions of an update wait for the divider, which works bit-serially
// in 32+FRAC_BITS steps. The first predict after reset only clears the
// first-step flag and goes straight to the result stage without micro-ops.
// A result is held in the output register until o_out.ready; the next beat
// may be accepted meanwhile but its result waits for that register.
// Synchronous active-low reset clears the state, restores the default noise
// values and arms the first-step flag.
`timescale 1ns / 1ps
`default_nettype none

module altitude_kalman_filter_2state_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    akf_in_if.sink     i_in,
    akf_cfg_if.sink    i_cfg,
    akf_out_if.source  o_out
);
    akf_pkg::t_state            r_state;
    akf_pkg::t_state            n_state;
    logic [akf_pkg::PC_W-1:0]   r_pc;
    logic [akf_pkg::PC_W-1:0]   n_pc;
    logic                       r_first;
    logic                       r_out_valid;
    logic signed [31:0]         r_out_pos;
    logic signed [31:0]         r_out_vel;
    logic signed [31:0]         r_out_gain;
    logic                       r_out_ovf;

    akf_pkg::t_uop    w_uop;
    akf_pkg::t_dp_ctl w_ctl;
    logic             w_in_acc;
    logic             w_out_load;
    logic             w_div_done;
    logic signed [31:0] w_pos;
    logic signed [31:0] w_vel;
    logic signed [31:0] w_gain;
    logic             w_ovf;

    assign w_uop      = akf_pkg::uop_rom(r_pc);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == akf_pkg::ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            akf_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (!i_in.mode && r_first) ? akf_pkg::ST_DONE : akf_pkg::ST_READ;
                end
            end
            akf_pkg::ST_READ:  n_state = akf_pkg::ST_EXEC;
            akf_pkg::ST_EXEC: begin
                n_state = (w_uop.op == akf_pkg::OP_DIV) ? akf_pkg::ST_DIVW : akf_pkg::ST_WRITE;
            end
            akf_pkg::ST_DIVW: begin
                if (w_div_done) begin
                    n_state = akf_pkg::ST_WRITE;
                end
            end
            akf_pkg::ST_WRITE: begin
                n_state = w_uop.last ? akf_pkg::ST_DONE : akf_pkg::ST_READ;
            end
            akf_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = akf_pkg::ST_IDLE;
                end
            end
            default: n_state = akf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready    = (r_state == akf_pkg::ST_IDLE);
        i_cfg.ready   = 1'b1;
        w_ctl.load_in = w_in_acc;
        w_ctl.rd      = (r_state == akf_pkg::ST_READ);
        w_ctl.ex      = (r_state == akf_pkg::ST_EXEC);
        w_ctl.wr      = (r_state == akf_pkg::ST_WRITE);
        w_ctl.uop     = w_uop;
    end

    always_comb begin
        n_pc = r_pc;
        if (w_in_acc) begin
            n_pc = i_in.mode ? akf_pkg::PC_UPDATE : akf_pkg::PC_PREDICT;
        end else if ((r_state == akf_pkg::ST_WRITE) && !w_uop.last) begin
            n_pc = r_pc + akf_pkg::PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= akf_pkg::ST_IDLE;
            r_pc        <= akf_pkg::PC_PREDICT;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (w_in_acc && !i_in.mode) begin
                r_first <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pos  <= w_pos;
            r_out_vel  <= w_vel;
            r_out_gain <= w_gain;
            r_out_ovf  <= w_ovf;
        end
    end

    akf_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_accel    (i_in.accel),
        .i_delta_t  (i_in.delta_t),
        .i_altitude (i_in.altitude),
        .i_cfg_we   (i_cfg.valid && i_cfg.ready),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .o_div_done (w_div_done),
        .o_position (w_pos),
        .o_velocity (w_vel),
        .o_gain     (w_gain),
        .o_ovf      (w_ovf)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.position      = r_out_pos;
    assign o_out.velocity      = r_out_vel;
    assign o_out.velocity_gain = r_out_gain;
    assign o_out.overflow      = r_out_ovf;

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == akf_pkg::ST_DIVW) |-> (w_uop.op == akf_pkg::OP_DIV))
        else $error("divider wait outside a divide micro-op");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in.ready)
        else $error("input accepted while an item is in flight");

    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == akf_pkg::ST_WRITE) && w_uop.last) |=> (r_state == akf_pkg::ST_DONE))
        else $error("sequence end did not reach result stage");

    a_done_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == akf_pkg::ST_DIVW))
        else $error("divider finished with no divide pending");

endmodule

`default_nettype wire

// ----- sim/akf_tb_if.sv -----
// Testbench-side note: the channel interfaces come from the RTL (akf_in_if,
// akf_out_if, akf_cfg_if). This file holds the shared beat type of the bench.
// Depends on nothing.
`timescale 1ns / 1ps

package akf_tb_pkg;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] velocity_gain;
        logic               overflow;
    } t_estimate;

endpackage

// ----- sim/akf_checker.sv -----
// Checker for the altitude Kalman filter: watches the input, config and result
// channels, keeps its own filter state, and compares every result beat.
// Depends on akf_pkg, akf_tb_pkg and the akf_*_if interfaces.
`timescale 1ns / 1ps

module akf_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    akf_in_if          i_in,
    akf_cfg_if         i_cfg,
    akf_out_if         i_out,
    output int         o_errors,
    output int         o_pending
);

    localparam int FB = 16;
    localparam longint ONE  = longint'(1) << FB;
    localparam longint HALF = longint'(1) << (FB - 1);

    logic signed [31:0] q_noise, r_noise;
    logic signed [31:0] pos, vel, ppp, ppv, pvp, pvv, gain;
    logic               first_pred;
    bit                 clipped;
    akf_tb_pkg::t_estimate estimates[$];

    function automatic logic signed [31:0] clip(input longint v);
        if (v > 64'sd2147483647) begin
            clipped = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + HALF;
        return clip(p >>> FB);
    endfunction

    function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return clip(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return clip(longint'(a) - longint'(b));
    endfunction

    task automatic advance(input logic signed [31:0] acc, input logic signed [31:0] dt);
        logic signed [31:0] half_dt2, a, b, n10;
        half_dt2 = fx_mul(fx_mul(dt, dt), 32'(HALF));
        pos = fx_add(fx_add(pos, fx_mul(dt, vel)), fx_mul(half_dt2, acc));
        vel = fx_add(vel, fx_mul(dt, acc));
        a   = fx_add(ppp, fx_mul(dt, pvp));
        b   = fx_add(ppv, fx_mul(dt, pvv));
        n10 = fx_add(pvp, fx_mul(dt, pvv));
        ppp = fx_add(fx_add(a, fx_mul(b, dt)), q_noise);
        ppv = b;
        pvp = n10;
        pvv = fx_add(pvv, q_noise);
    endtask

    task automatic correct(input logic signed [31:0] alt);
        longint den;
        logic signed [31:0] k0, k1, y, c, nk, kr0, kr1, m00, m01, m10, m11;
        den = longint'(ppp) + longint'(r_noise);
        k0 = 0;
        k1 = 0;
        if (den != 0) begin
            k0 = clip((longint'(ppp) * ONE) / den);
            k1 = clip((longint'(pvp) * ONE) / den);
        end
        y   = fx_sub(alt, pos);
        pos = fx_add(pos, fx_mul(k0, y));
        vel = fx_add(vel, fx_mul(k1, y));
        c   = fx_sub(32'(ONE), k0);
        nk  = fx_sub(0, k1);
        m00 = fx_mul(c, ppp);
        m01 = fx_mul(c, ppv);
        m10 = fx_add(fx_mul(nk, ppp), pvp);
        m11 = fx_add(fx_mul(nk, ppv), pvv);
        kr0 = fx_mul(k0, r_noise);
        kr1 = fx_mul(k1, r_noise);
        ppp = fx_add(fx_mul(m00, c), fx_mul(kr0, k0));
        ppv = fx_add(fx_add(fx_mul(m00, nk), m01), fx_mul(kr0, k1));
        pvp = fx_add(fx_mul(m10, c), fx_mul(kr1, k0));
        pvv = fx_add(fx_add(fx_mul(m10, nk), m11), fx_mul(kr1, k1));
        gain = k1;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        akf_tb_pkg::t_estimate e, g;
        if (!i_rst_n) begin
            q_noise    = 32'sd4915;
            r_noise    = 32'sd6554;
            {pos, vel, ppp, ppv, pvp, pvv, gain} = '0;
            first_pred = 1;
            estimates.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == akf_pkg::CFG_PROCESS_NOISE)
                    q_noise = {1'b0, i_cfg.data};
                else if (i_cfg.index == akf_pkg::CFG_MEASUREMENT_NOISE)
                    r_noise = {1'b0, i_cfg.data};
            end
            if (i_out.valid && i_out.ready) begin
                g = '{i_out.position, i_out.velocity, i_out.velocity_gain,
                      i_out.overflow};
                if (estimates.size() == 0) begin
                    report("unexpected result beat", 0, 0);
                end else begin
                    e = estimates.pop_front();
                    if (g.position !== e.position)
                        report("position", g.position, e.position);
                    if (g.velocity !== e.velocity)
                        report("velocity", g.velocity, e.velocity);
                    if (g.velocity_gain !== e.velocity_gain)
                        report("velocity_gain", g.velocity_gain, e.velocity_gain);
                    if (g.overflow !== e.overflow)
                        report("overflow", g.overflow, e.overflow);
                end
            end
            if (i_in.valid && i_in.ready) begin
                clipped = 0;
                if (i_in.mode == 1'b0) begin
                    if (!first_pred)
                        advance(i_in.accel, {8'd0, i_in.delta_t});
                    first_pred = 0;
                end else begin
                    correct(i_in.altitude);
                end
                estimates.push_back('{pos, vel, gain, clipped});
            end
        end
        o_pending = estimates.size();
    end

endmodule

// ----- sim/altitude_kalman_filter_2state_core_tb.sv -----
// Top of the altitude Kalman filter bench: clock, reset, stimulus, receiver
// stalls and verdict. Depends on the core, akf_checker and the interfaces.
`timescale 1ns / 1ps

module altitude_kalman_filter_2state_core_tb;

    localparam int N_RANDOM   = 1700;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending;
    bit   hold_off = 0;
    bit   rx_stall_on = 1;

    akf_in_if  in_ch();
    akf_cfg_if cfg_ch();
    akf_out_if out_ch();

    altitude_kalman_filter_2state_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    akf_checker i_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .i_out   (out_ch),
        .o_errors(errors),
        .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Receiver: random stalls in bursts, or a long hold-off when asked.
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off)
                out_ch.ready <= 0;
            else if (!rx_stall_on)
                out_ch.ready <= 1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        forever begin
            repeat ($urandom_range(200, 2000)) @(negedge i_clk);
            rx_stall_on = !rx_stall_on;
        end
    end

    // Ends the run when no beat moves for too long.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic mode, input logic [31:0] acc,
                             input logic [23:0] dt, input logic [31:0] alt);
        in_ch.valid    <= 1;
        in_ch.mode     <= mode;
        in_ch.accel    <= acc;
        in_ch.delta_t  <= dt;
        in_ch.altitude <= alt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_in();
        in_ch.valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // Mostly realistic altitudes and small time steps, with some wild values.
    task automatic random_beat();
        logic [23:0] dt;
        if ($urandom_range(0, 9) == 0)
            dt = 24'($urandom);
        else
            dt = 24'($urandom_range(0, 6554));
        if ($urandom_range(0, 4) == 0)
            send_beat(1'($urandom_range(0, 1)), rand_word(), dt, rand_word());
        else
            send_beat(1'($urandom_range(0, 1)),
                      32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)), dt,
                      32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16)));
    endtask

    initial begin
        int burst;
        in_ch.valid = 0;
        in_ch.mode = 0;
        in_ch.accel = 0;
        in_ch.delta_t = 0;
        in_ch.altitude = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = akf_pkg::CFG_PROCESS_NOISE;
        cfg_ch.data = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: update before any predict, the skipped first predict,
        // field extremes, and a zero denominator.
        send_beat(1, 32'h0001_0000, 0, 32'h0064_0000);
        send_beat(0, 32'h7fffffff, 24'hffffff, 0);
        send_beat(0, 32'h0001_0000, 24'h000a00, 0);
        send_beat(0, 32'h80000000, 24'hffffff, 0);
        send_beat(0, 32'h7fffffff, 24'hffffff, 0);
        send_beat(1, 0, 0, 32'h7fffffff);
        send_beat(1, 0, 0, 32'h80000000);
        send_beat(0, 32'hffff_0000, 24'h000000, 32'hffffffff);
        send_beat(1, 32'hffffffff, 24'hffffff, 32'h00000000);
        drain();
        write_reg(akf_pkg::CFG_PROCESS_NOISE, 0);
        write_reg(akf_pkg::CFG_MEASUREMENT_NOISE, 0);
        send_beat(1, 0, 0, 32'h0010_0000);
        send_beat(0, 32'h0002_0000, 24'h001000, 0);
        send_beat(1, 0, 0, 32'h0010_0000);
        drain();
        write_reg(akf_pkg::CFG_PROCESS_NOISE, 31'h7fffffff);
        write_reg(akf_pkg::CFG_MEASUREMENT_NOISE, 31'h7fffffff);
        send_beat(0, 32'h0001_0000, 24'h008000, 0);
        send_beat(1, 0, 0, 32'h0100_0000);
        send_beat(1, 0, 0, 32'h0100_0000);
        drain();
        write_reg(2'd2, 31'h1234);
        write_reg(2'd3, 31'h5678);
        write_reg(akf_pkg::CFG_PROCESS_NOISE, 4915);
        write_reg(akf_pkg::CFG_MEASUREMENT_NOISE, 6554);

        // Receiver holds off while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (1500) @(negedge i_clk);
                hold_off = 0;
            end
            repeat (12) random_beat();
        join
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 400 == 399) begin
                drain();
                write_reg(akf_pkg::CFG_PROCESS_NOISE, 31'($urandom_range(0, 1 << 20)));
                write_reg(akf_pkg::CFG_MEASUREMENT_NOISE,
                          ($urandom_range(0, 7) == 0) ? 31'h7fffffff
                                                      : 31'($urandom_range(1, 1 << 20)));
            end
            random_beat();
            burst = burst - 1;
            if (burst <= 0) begin
                burst = $urandom_range(1, 20);
                repeat ($urandom_range(0, 200)) pause_in();
            end
        end
        in_ch.valid <= 0;

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/akf_pkg.sv
hw/rtl/akf_in_if.sv
hw/rtl/akf_out_if.sv
hw/rtl/akf_cfg_if.sv
hw/rtl/akf_div.sv
hw/rtl/akf_dp.sv
hw/rtl/altitude_kalman_filter_2state_core.sv
sim/akf_tb_if.sv
sim/akf_checker.sv
sim/altitude_kalman_filter_2state_core_tb.sv
